>>> design/mrcc_pkg.sv
// Shared constants and controller/datapath types for the range coverage check
`timescale 1ns / 1ps

package mrcc_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int ADDR_W  = 64;
  localparam int TYPE_W  = 4;
  localparam int COUNT_W = 7;
  localparam int MASK_W  = 16;

  // Register indexes on the configuration port
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_MASK  = 1'b1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic              accept;   // latch an incoming word
    logic              issue;    // read one table entry into the walk
    logic [SLOT_W-1:0] rd_addr;  // entry being read
    logic              load_out; // move the answer into the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;     // walk pipeline still holds entries
    logic out_free; // output register can take a word this cycle
  } dp_status_t;

endpackage

>>> design/mrcc_ifs.sv
// Handshake channel interfaces for request and response words
`timescale 1ns / 1ps

interface mrcc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  entry_slot;
  logic [63:0] entry_start;
  logic [63:0] entry_size;
  logic [3:0]  entry_type;
  logic [63:0] range_start;
  logic [63:0] range_end;

  modport source (output valid, kind, entry_slot, entry_start, entry_size, entry_type,
                  range_start, range_end, input ready);
  modport sink (input valid, kind, entry_slot, entry_start, entry_size, entry_type,
                range_start, range_end, output ready);
endinterface

interface mrcc_rsp_if;
  logic valid;
  logic ready;
  logic answer_valid;
  logic range_covered;

  modport source (output valid, answer_valid, range_covered, input ready);
  modport sink (input valid, answer_valid, range_covered, output ready);
endinterface

>>> design/mrcc_ctrl.sv
// Controller state machine: accepts words, sequences the table walk, hands off answers
`timescale 1ns / 1ps

module mrcc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_kind,
  output logic                         req_ready,
  input  logic [mrcc_pkg::COUNT_W-1:0] cfg_count,
  input  mrcc_pkg::dp_status_t         status,
  output mrcc_pkg::ctl_cmd_t           cmd
);
  import mrcc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] limit, limit_next;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] cfg_limit;
  logic             accept;

  // Saturate the configured count at the table depth
  always_comb begin
    if (int'(cfg_count) > TABLE_DEPTH) cfg_limit = CNT_W'(TABLE_DEPTH);
    else                               cfg_limit = CNT_W'(cfg_count);
  end

  assign req_ready = (state == S_IDLE);
  assign accept    = req_ready & req_valid;
  assign idx_inc   = idx + CNT_W'(1);

  // Next state and commands
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    limit_next   = limit;
    cmd.accept   = accept;
    cmd.issue    = 1'b0;
    cmd.rd_addr  = idx[SLOT_W-1:0];
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          limit_next = cfg_limit;
          if (req_kind == KIND_QUERY) begin
            state_next = (cfg_limit == '0) ? S_DRAIN : S_WALK;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        idx_next  = idx_inc;
        if (idx_inc == limit) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      limit <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      limit <= limit_next;
    end
  end

endmodule

>>> design/mrcc_datapath.sv
// Datapath: region table memory, pipelined overlap walk and output register
`timescale 1ns / 1ps

module mrcc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  mrcc_req_if.sink                    req,
  mrcc_rsp_if.source                  rsp,
  input  logic [mrcc_pkg::MASK_W-1:0] cfg_mask,
  input  mrcc_pkg::ctl_cmd_t          cmd,
  output mrcc_pkg::dp_status_t        status
);
  import mrcc_pkg::*;

  // Region table
  logic [ADDR_W-1:0] mem_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] mem_size  [TABLE_DEPTH];
  logic [TYPE_W-1:0] mem_type  [TABLE_DEPTH];

  // Query context
  logic              is_query;
  logic [ADDR_W-1:0] lo, hi, remaining;
  logic              hit;

  // Walk pipeline
  logic              a_valid;
  logic [ADDR_W-1:0] a_start, a_size;
  logic [TYPE_W-1:0] a_type;
  logic              b_ok, b_carry;
  logic [ADDR_W-1:0] b_rlo, b_rhi;
  logic              c_ovl;
  logic [ADDR_W-1:0] c_bottom, c_top;
  logic              d_valid;
  logic [ADDR_W-1:0] d_delta;
  logic              e_chk;

  // Output register
  logic              out_valid, out_answer, out_covered;

  logic              b_use, b_contains, b_overlap;
  logic              wr_en;

  assign wr_en = cmd.accept && (req.kind == KIND_WRITE) && (int'(req.entry_slot) < TABLE_DEPTH);

  // Write an entry on an accepted write word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[SLOT_W'(req.entry_slot)] <= req.entry_start;
      mem_size[SLOT_W'(req.entry_slot)]  <= req.entry_size;
      mem_type[SLOT_W'(req.entry_slot)]  <= req.entry_type;
    end
  end

  // Read one entry per walk step
  always_ff @(posedge clk) begin
    a_start <= mem_start[cmd.rd_addr];
    a_size  <= mem_size[cmd.rd_addr];
    a_type  <= mem_type[cmd.rd_addr];
  end

  // Region end with overflow flag (the type filter sits with the valid flags)
  always_ff @(posedge clk) begin
    {b_carry, b_rhi} <= {1'b0, a_start} + {1'b0, a_size};
    b_rlo            <= a_start;
  end

  // Containment and overlap against the query range
  always_comb begin
    b_use      = b_ok & ~b_carry;
    b_contains = (lo >= b_rlo) && (lo < b_rhi) && (hi > b_rlo) && (hi <= b_rhi);
    b_overlap  = (b_rlo < hi) && (b_rhi > lo);
  end

  always_ff @(posedge clk) begin
    c_bottom <= (b_rlo > lo) ? b_rlo : lo;
    c_top    <= (b_rhi < hi) ? b_rhi : hi;
    d_delta  <= c_top - c_bottom;
  end

  // Pipeline valid flags, remainder and hit tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_ok    <= 1'b0;
      c_ovl   <= 1'b0;
      d_valid <= 1'b0;
      e_chk   <= 1'b0;
      hit     <= 1'b0;
    end else begin
      a_valid <= cmd.issue;
      b_ok    <= a_valid & cfg_mask[a_type];
      c_ovl   <= b_use & b_overlap;
      d_valid <= c_ovl;
      e_chk   <= d_valid;
      if (cmd.accept) begin
        hit <= 1'b0;
      end else if ((b_use && b_contains) || (e_chk && (remaining == '0))) begin
        hit <= 1'b1;
      end
    end
  end

  // Latch the query range and initial remainder
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_query  <= (req.kind == KIND_QUERY);
      lo        <= req.range_start;
      hi        <= req.range_end;
      remaining <= req.range_end - req.range_start;
    end else if (d_valid) begin
      remaining <= remaining - d_delta;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_answer  <= is_query;
      out_covered <= is_query & hit;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.answer_valid  = out_answer;
  assign rsp.range_covered = out_covered;

  assign status.busy     = a_valid | b_ok | c_ovl | d_valid | e_chk;
  assign status.out_free = ~out_valid | rsp.ready;

endmodule

>>> design/memory_range_coverage_check.sv
// Top level: configuration registers, controller and datapath of the range coverage check
//
//   Channel  Dir  Handshake            Word
//   req      in   valid/ready          kind, entry_slot/start/size/type, range_start/end
//   rsp      out  valid/ready          answer_valid, range_covered
//   cfg      in   APB psel/penable     0x0 entries_in_use, 0x4 accepted_type_mask
//
// A write word passes through the finish state and enters the output register once it is free.
// A query first walks the table: the single table read port reads one entry per cycle,
// up to the saturated entry count (no walk when that count is zero), into a five-stage
// overlap pipeline, which drains before the answer goes to the output register.
// Synchronous active-high reset clears control state and registers; the table is not cleared.
// A waiting output word does not block the next request; a new answer waits for the slot.
`timescale 1ns / 1ps

module memory_range_coverage_check (
  input  logic        clk,
  input  logic        rst,
  mrcc_req_if.sink    req,
  mrcc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrcc_pkg::*;

  logic [COUNT_W-1:0] entries_in_use;
  logic [MASK_W-1:0]  accepted_type_mask;
  logic               cfg_wr;
  ctl_cmd_t           cmd;
  dp_status_t         status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use     <= '0;
      accepted_type_mask <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COUNT: entries_in_use     <= pwdata[COUNT_W-1:0];
        REG_MASK:  accepted_type_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_COUNT: prdata = {{(32 - COUNT_W){1'b0}}, entries_in_use};
      REG_MASK:  prdata = {{(32 - MASK_W){1'b0}}, accepted_type_mask};
      default:   prdata = '0;
    endcase
  end

  mrcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .cfg_count (entries_in_use),
    .status    (status),
    .cmd       (cmd)
  );

  mrcc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_mask (accepted_type_mask),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

>>> design/mrcc_checker.sv
// Port-level assertions for the range coverage check, bound to the top level
`timescale 1ns / 1ps

module mrcc_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_kind,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_answer_valid,
  input logic rsp_range_covered
);

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response word present after reset");

  // An accepted request blocks the next one until the controller is idle again
  assert property (@(posedge clk) disable iff (rst)
                   (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous word still in progress");

  // Hold a stalled response word
  assert property (@(posedge clk) disable iff (rst)
                   (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
                   (rsp_valid && !rsp_ready) |=>
                   ($stable(rsp_answer_valid) && $stable(rsp_range_covered)))
    else $error("response payload changed while stalled");

  // A write acknowledgement never reports coverage
  assert property (@(posedge clk) disable iff (rst)
                   (req_valid && req_ready && !req_kind) |=> ##2
                   (!rsp_valid || rsp_answer_valid || !rsp_range_covered))
    else $error("write acknowledgement carries a coverage flag");

endmodule

bind memory_range_coverage_check mrcc_checker u_mrcc_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_kind          (req.kind),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_answer_valid  (rsp.answer_valid),
  .rsp_range_covered (rsp.range_covered)
);
